// ===== src/grid_cell_locator_core_macros.svh =====
`ifndef GRID_CELL_LOCATOR_CORE_MACROS_SVH
`define GRID_CELL_LOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define GLC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GLC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/glc_pkg.sv =====
package glc_pkg;

   localparam int GRID_DEPTH_DEF = 1024;
   localparam int NUM_GRIDS      = 4;
   localparam int LEN_W          = 11;
   localparam int IDX_W          = 10;
   localparam int VAL_W          = 32;
   localparam int SEL_W          = 2;
   localparam int CSR_IDX_W      = 3;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOCATE = 1'b1;

   localparam logic [SEL_W-1:0] GRID_TIME = 2'd0;
   localparam logic [SEL_W-1:0] GRID_X    = 2'd1;
   localparam logic [SEL_W-1:0] GRID_Y    = 2'd2;
   localparam logic [SEL_W-1:0] GRID_Z    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TIME_LEN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_EDGES  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_EDGES  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_EDGES  = 3'd3;

   localparam logic [LEN_W-1:0] TIME_LEN_MIN = 11'd1;
   localparam logic [LEN_W-1:0] EDGE_LEN_MIN = 11'd2;

   typedef struct packed {
      logic start;
      logic probe;
      logic cmp;
   } lane_ctrl_type;

   typedef struct packed {
      logic             busy;
      logic [LEN_W-1:0] lower;
   } lane_stat_type;

   function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] v,
                                                  logic [LEN_W-1:0] lo,
                                                  int depth);
      if (v < lo) begin
         return lo;
      end else if (int'(v) > depth) begin
         return LEN_W'(depth);
      end
      return v;
   endfunction

endpackage

// ===== src/glc_if.sv =====
interface glc_req_if;
   logic                             valid;
   logic                             ready;
   logic                             cmd;
   logic [glc_pkg::SEL_W-1:0]        grid_sel;
   logic [glc_pkg::IDX_W-1:0]        entry_index;
   logic signed [glc_pkg::VAL_W-1:0] entry_value;
   logic signed [glc_pkg::VAL_W-1:0] time_coord;
   logic signed [glc_pkg::VAL_W-1:0] x_coord;
   logic signed [glc_pkg::VAL_W-1:0] y_coord;
   logic signed [glc_pkg::VAL_W-1:0] z_coord;

   modport source (output valid, cmd, grid_sel, entry_index, entry_value,
                   time_coord, x_coord, y_coord, z_coord, input ready);
   modport sink (input valid, cmd, grid_sel, entry_index, entry_value,
                 time_coord, x_coord, y_coord, z_coord, output ready);
endinterface

interface glc_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [glc_pkg::IDX_W-1:0] time_index;
   logic [glc_pkg::IDX_W-1:0] x_cell;
   logic [glc_pkg::IDX_W-1:0] y_cell;
   logic [glc_pkg::IDX_W-1:0] z_cell;

   modport source (output valid, time_index, x_cell, y_cell, z_cell, input ready);
   modport sink (input valid, time_index, x_cell, y_cell, z_cell, output ready);
endinterface

interface glc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [glc_pkg::CSR_IDX_W-1:0] index;
   logic [glc_pkg::LEN_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/glc_ram.sv =====
module glc_ram #(
   parameter int WIDTH = glc_pkg::VAL_W,
   parameter int DEPTH = glc_pkg::GRID_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/glc_lane.sv =====
module glc_lane #(
   parameter int GRID_DEPTH = glc_pkg::GRID_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  glc_pkg::lane_ctrl_type           ctrl,
   input  logic [glc_pkg::LEN_W-1:0]        len,
   input  logic signed [glc_pkg::VAL_W-1:0] key,
   input  logic                             wr_en,
   input  logic [glc_pkg::IDX_W-1:0]        wr_index,
   input  logic signed [glc_pkg::VAL_W-1:0] wr_value,
   output glc_pkg::lane_stat_type           stat,
   output logic signed [glc_pkg::VAL_W-1:0] lo_val,
   output logic signed [glc_pkg::VAL_W-1:0] hi_val
);

   localparam int ADDR_W = $clog2(GRID_DEPTH);
   localparam int LW     = glc_pkg::LEN_W;
   localparam int VW     = glc_pkg::VAL_W;

   logic [LW-1:0]        first_ff, first_in;
   logic [LW-1:0]        count_ff, count_in;
   logic [LW-1:0]        probe_ff, probe_in;
   logic [LW-1:0]        half_ff, half_in;
   logic                 act_ff, act_in;
   logic signed [VW-1:0] key_ff, key_in;
   logic signed [VW-1:0] lo_ff, lo_in;
   logic signed [VW-1:0] hi_ff, hi_in;
   logic [LW-1:0]        probe_c;
   logic [VW-1:0]        rd_data;
   logic signed [VW-1:0] entry;

   assign probe_c = first_ff + (count_ff >> 1);
   assign entry   = signed'(rd_data);

   glc_ram #(.WIDTH(VW), .DEPTH(GRID_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(wr_index)),
      .wr_data (wr_value),
      .rd_addr (ADDR_W'(probe_c)),
      .rd_data (rd_data)
   );

   always_comb begin
      first_in = first_ff;
      count_in = count_ff;
      probe_in = probe_ff;
      half_in  = half_ff;
      act_in   = act_ff;
      key_in   = key_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      if (ctrl.start) begin
         first_in = '0;
         count_in = len;
         key_in   = key;
      end
      if (ctrl.probe) begin
         probe_in = probe_c;
         half_in  = count_ff >> 1;
         act_in   = (count_ff != '0);
      end
      if (ctrl.cmp && act_ff) begin
         if (entry < key_ff) begin
            first_in = probe_ff + LW'(1);
            count_in = count_ff - half_ff - LW'(1);
            lo_in    = entry;
         end else begin
            count_in = half_ff;
            hi_in    = entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         count_ff <= '0;
         act_ff   <= 1'b0;
      end else begin
         first_ff <= first_in;
         count_ff <= count_in;
         act_ff   <= act_in;
      end
      probe_ff <= probe_in;
      half_ff  <= half_in;
      key_ff   <= key_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
   end

   assign stat.busy  = (count_ff != '0);
   assign stat.lower = first_ff;
   assign lo_val     = lo_ff;
   assign hi_val     = hi_ff;

endmodule

// ===== src/grid_cell_locator_core.sv =====
// grid_cell_locator_core: maps a particle's t, x, y, z onto four loaded grids.
//
// req_ch carries requests. cmd LOAD writes entry_value into entry_index of the
// grid picked by grid_sel, gives no response, and is ignored when the index is
// past the grid depth. cmd LOCATE runs a lower-bound search on all four grids
// side by side and returns one response on rsp_ch: nearest time center and the
// x, y, z cell indices.
// csr_ch writes the four grid lengths (always ready); write them only while idle.
// A locate runs up to bit-length(longest clamped grid length) probes (11 for
// 1024), each a PROBE and a CMP state, then finishes through a last PROBE check
// and the DIFF, ABSV and PICK states; req_ch.ready returns high as the response
// turns valid. Each probe waits out the registered read of the grid RAMs before
// the compare that picks the next probe.
// req_ch.ready is low while a locate is in flight; loads are taken back to back.
// The response sits in an output register; a stalled receiver holds it, loads
// are still accepted meanwhile, and the next locate waits to finish until the
// register frees. Reset clears the control state and sets the lengths to 1, 2,
// 2, 2; grid contents are undefined until loaded.
`include "grid_cell_locator_core_macros.svh"

module grid_cell_locator_core #(
   parameter int GRID_DEPTH = glc_pkg::GRID_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   glc_req_if.sink   req_ch,
   glc_rsp_if.source rsp_ch,
   glc_csr_if.sink   csr_ch
);

   localparam int NG = glc_pkg::NUM_GRIDS;
   localparam int LW = glc_pkg::LEN_W;
   localparam int VW = glc_pkg::VAL_W;
   localparam int IW = glc_pkg::IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP,
      ST_DIFF,
      ST_ABSV,
      ST_PICK
   } state_type;

   state_type            state_ff, state_in;
   logic [LW-1:0]        len_ff [NG];
   logic [LW-1:0]        len_in [NG];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]        rsp_t_ff, rsp_t_in;
   logic [IW-1:0]        rsp_x_ff, rsp_x_in;
   logic [IW-1:0]        rsp_y_ff, rsp_y_in;
   logic [IW-1:0]        rsp_z_ff, rsp_z_in;
   logic signed [VW-1:0] tkey_ff, tkey_in;
   logic [VW:0]          dhi_ff, dhi_in;
   logic [VW:0]          dlo_ff, dlo_in;
   logic [VW:0]          ahi_ff, ahi_in;
   logic [VW:0]          alo_ff, alo_in;

   glc_pkg::lane_ctrl_type ctrl;
   glc_pkg::lane_stat_type stat [NG];
   logic signed [VW-1:0]   lo_val [NG];
   logic signed [VW-1:0]   hi_val [NG];
   logic signed [VW-1:0]   keys [NG];
   logic [LW-1:0]          n_len [NG];
   logic [NG-1:0]          busy;
   logic                   any_busy;
   logic                   req_fire;
   logic                   load_ok;
   logic [LW-1:0]          t_res;
   logic [LW-1:0]          cell_res [NG];

   assign req_fire = req_ch.valid && req_ch.ready;
   assign load_ok  = req_fire && (req_ch.cmd == glc_pkg::CMD_LOAD) &&
                     (int'(req_ch.entry_index) < GRID_DEPTH);

   assign keys[0] = req_ch.time_coord;
   assign keys[1] = req_ch.x_coord;
   assign keys[2] = req_ch.y_coord;
   assign keys[3] = req_ch.z_coord;

   assign n_len[0] = glc_pkg::clamp_len(len_ff[0], glc_pkg::TIME_LEN_MIN, GRID_DEPTH);

   for (genvar g = 0; g < NG; g++) begin : g_lane
      if (g > 0) begin : g_edge_len
         assign n_len[g] = glc_pkg::clamp_len(len_ff[g], glc_pkg::EDGE_LEN_MIN, GRID_DEPTH);
      end

      glc_lane #(.GRID_DEPTH(GRID_DEPTH)) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .len      (n_len[g]),
         .key      (keys[g]),
         .wr_en    (load_ok && (req_ch.grid_sel == glc_pkg::SEL_W'(g))),
         .wr_index (req_ch.entry_index),
         .wr_value (req_ch.entry_value),
         .stat     (stat[g]),
         .lo_val   (lo_val[g]),
         .hi_val   (hi_val[g])
      );

      assign busy[g] = stat[g].busy;

      always_comb begin
         if (stat[g].lower == '0) begin
            cell_res[g] = '0;
         end else if (stat[g].lower >= n_len[g]) begin
            cell_res[g] = n_len[g] - LW'(2);
         end else begin
            cell_res[g] = stat[g].lower - LW'(1);
         end
      end
   end

   assign any_busy = |busy;

   always_comb begin
      if (stat[0].lower == '0) begin
         t_res = '0;
      end else if (stat[0].lower >= n_len[0]) begin
         t_res = n_len[0] - LW'(1);
      end else if (ahi_ff < alo_ff) begin
         t_res = stat[0].lower;
      end else begin
         t_res = stat[0].lower - LW'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_t_in     = rsp_t_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      tkey_in      = tkey_ff;
      dhi_in       = dhi_ff;
      dlo_in       = dlo_ff;
      ahi_in       = ahi_ff;
      alo_in       = alo_ff;
      ctrl         = '0;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            glc_pkg::CSR_TIME_LEN: len_in[0] = csr_ch.data;
            glc_pkg::CSR_X_EDGES:  len_in[1] = csr_ch.data;
            glc_pkg::CSR_Y_EDGES:  len_in[2] = csr_ch.data;
            glc_pkg::CSR_Z_EDGES:  len_in[3] = csr_ch.data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_ch.cmd == glc_pkg::CMD_LOCATE)) begin
               ctrl.start = 1'b1;
               tkey_in    = req_ch.time_coord;
               state_in   = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (any_busy) begin
               ctrl.probe = 1'b1;
               state_in   = ST_CMP;
            end else begin
               state_in = ST_DIFF;
            end
         end
         ST_CMP: begin
            ctrl.cmp = 1'b1;
            state_in = ST_PROBE;
         end
         ST_DIFF: begin
            dhi_in   = {hi_val[0][VW-1], hi_val[0]} - {tkey_ff[VW-1], tkey_ff};
            dlo_in   = {lo_val[0][VW-1], lo_val[0]} - {tkey_ff[VW-1], tkey_ff};
            state_in = ST_ABSV;
         end
         ST_ABSV: begin
            ahi_in   = dhi_ff[VW] ? (~dhi_ff + (VW+1)'(1)) : dhi_ff;
            alo_in   = dlo_ff[VW] ? (~dlo_ff + (VW+1)'(1)) : dlo_ff;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_t_in     = IW'(t_res);
               rsp_x_in     = IW'(cell_res[1]);
               rsp_y_in     = IW'(cell_res[2]);
               rsp_z_in     = IW'(cell_res[3]);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         len_ff[0]    <= glc_pkg::TIME_LEN_MIN;
         len_ff[1]    <= glc_pkg::EDGE_LEN_MIN;
         len_ff[2]    <= glc_pkg::EDGE_LEN_MIN;
         len_ff[3]    <= glc_pkg::EDGE_LEN_MIN;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
      end
      rsp_t_ff <= rsp_t_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_z_ff <= rsp_z_in;
      tkey_ff  <= tkey_in;
      dhi_ff   <= dhi_in;
      dlo_ff   <= dlo_in;
      ahi_ff   <= ahi_in;
      alo_ff   <= alo_in;
   end

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign csr_ch.ready      = 1'b1;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.time_index = rsp_t_ff;
   assign rsp_ch.x_cell     = rsp_x_ff;
   assign rsp_ch.y_cell     = rsp_y_ff;
   assign rsp_ch.z_cell     = rsp_z_ff;

   `GLC_ASSERT_IMP(a_idle_lanes_quiet, clock, reset, req_ch.ready, !any_busy, "search active while ready")
   `GLC_ASSERT_NXT(a_locate_blocks, clock, reset, req_fire && (req_ch.cmd == glc_pkg::CMD_LOCATE), !req_ch.ready, "ready right after locate")
   `GLC_ASSERT_IMP(a_rsp_from_pick, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_PICK), "response without finished search")
   `GLC_ASSERT_NXT(a_load_no_rsp, clock, reset, req_fire && (req_ch.cmd == glc_pkg::CMD_LOAD) && !rsp_valid_ff, !rsp_valid_ff, "load produced a response")

endmodule

// ===== sim/tb_grid_cell_locator_core.sv =====
`timescale 1ns / 1ps

module tb_grid_cell_locator_core;

   localparam int VAL_W          = glc_pkg::VAL_W;
   localparam int IDX_W          = glc_pkg::IDX_W;
   localparam int SEL_W          = glc_pkg::SEL_W;
   localparam int LEN_W          = glc_pkg::LEN_W;
   localparam int CSR_IDX_W      = glc_pkg::CSR_IDX_W;
   localparam int NUM_GRIDS      = glc_pkg::NUM_GRIDS;
   localparam int GRID_DEPTH_DEF = glc_pkg::GRID_DEPTH_DEF;

   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int ITEM_TARGET   = 1700;
   localparam int TAIL_ITEMS    = 150;

   localparam logic signed [VAL_W-1:0] Q_ONE   = 32'sh0001_0000;
   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   typedef logic [NUM_GRIDS-1:0][IDX_W-1:0] cell_set_type;

   typedef struct {
      logic                    cmd;
      logic [SEL_W-1:0]        grid_sel;
      logic [IDX_W-1:0]        entry_index;
      logic signed [VAL_W-1:0] entry_value;
      logic signed [VAL_W-1:0] coord [NUM_GRIDS];
   } grid_req_type;

   class cell_lookup_board;
      logic signed [VAL_W-1:0] grid [NUM_GRIDS][GRID_DEPTH_DEF];
      logic [LEN_W-1:0]        len_reg [NUM_GRIDS];
      cell_set_type            expected_cells [$];
      int                      errors;

      function new();
         errors = 0;
         len_reg[glc_pkg::GRID_TIME] = glc_pkg::TIME_LEN_MIN;
         len_reg[glc_pkg::GRID_X]    = glc_pkg::EDGE_LEN_MIN;
         len_reg[glc_pkg::GRID_Y]    = glc_pkg::EDGE_LEN_MIN;
         len_reg[glc_pkg::GRID_Z]    = glc_pkg::EDGE_LEN_MIN;
      endfunction

      function void set_len(logic [CSR_IDX_W-1:0] idx, logic [LEN_W-1:0] v);
         case (idx)
            glc_pkg::CSR_TIME_LEN: len_reg[glc_pkg::GRID_TIME] = v;
            glc_pkg::CSR_X_EDGES:  len_reg[glc_pkg::GRID_X]    = v;
            glc_pkg::CSR_Y_EDGES:  len_reg[glc_pkg::GRID_Y]    = v;
            glc_pkg::CSR_Z_EDGES:  len_reg[glc_pkg::GRID_Z]    = v;
            default: ;
         endcase
      endfunction

      // usable grid length after saturation
      function int unsigned span(int g);
         int unsigned lo, v;
         lo = (g == glc_pkg::GRID_TIME) ? 32'(glc_pkg::TIME_LEN_MIN)
                                        : 32'(glc_pkg::EDGE_LEN_MIN);
         v = 32'(len_reg[g]);
         if (v < lo) return lo;
         if (v > GRID_DEPTH_DEF) return GRID_DEPTH_DEF;
         return v;
      endfunction

      function int unsigned first_not_less(int g, int unsigned n,
                                           logic signed [VAL_W-1:0] key);
         int unsigned first, count, half;
         first = 0;
         count = n;
         while (count > 0) begin
            half = count / 2;
            if (grid[g][first + half] < key) begin
               first = first + half + 1;
               count = count - half - 1;
            end else begin
               count = half;
            end
         end
         return first;
      endfunction

      function void note_request(grid_req_type r);
         int unsigned  n, lb, pos;
         longint       d_hi, d_lo;
         cell_set_type want;
         if (r.cmd == glc_pkg::CMD_LOAD) begin
            grid[r.grid_sel][r.entry_index] = r.entry_value;
            return;
         end
         for (int g = 0; g < NUM_GRIDS; g++) begin
            n = span(g);
            lb = first_not_less(g, n, r.coord[g]);
            if (lb == 0) begin
               pos = 0;
            end else if (lb >= n) begin
               pos = (g == glc_pkg::GRID_TIME) ? n - 1 : n - 2;
            end else if (g != glc_pkg::GRID_TIME) begin
               pos = lb - 1;
            end else begin
               // nearest center, tie goes low
               d_hi = longint'(grid[g][lb]) - longint'(r.coord[g]);
               d_lo = longint'(grid[g][lb - 1]) - longint'(r.coord[g]);
               if (d_hi < 0) d_hi = -d_hi;
               if (d_lo < 0) d_lo = -d_lo;
               pos = (d_hi < d_lo) ? lb : lb - 1;
            end
            want[g] = IDX_W'(pos);
         end
         expected_cells.insert(expected_cells.size(), want);
      endfunction

      function void check_cells(cell_set_type got);
         cell_set_type want;
         string        names [NUM_GRIDS];
         names = '{"time_index", "x_cell", "y_cell", "z_cell"};
         if (expected_cells.size() == 0) begin
            $display("%0t: response with no locate pending, expected none, actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = expected_cells.pop_front();
         for (int g = 0; g < NUM_GRIDS; g++) begin
            if (got[g] !== want[g]) begin
               $display("%0t: %s expected %0d actual %0d", $time, names[g], want[g],
                        got[g]);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   glc_req_if req_bus ();
   glc_rsp_if rsp_bus ();
   glc_csr_if csr_bus ();

   grid_cell_locator_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   cell_lookup_board board = new();
   bit quiet     = 1'b0;
   int sent      = 0;
   int hold_asks = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic send_request(grid_req_type r);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.cmd         <= r.cmd;
      req_bus.grid_sel    <= r.grid_sel;
      req_bus.entry_index <= r.entry_index;
      req_bus.entry_value <= r.entry_value;
      req_bus.time_coord  <= r.coord[glc_pkg::GRID_TIME];
      req_bus.x_coord     <= r.coord[glc_pkg::GRID_X];
      req_bus.y_coord     <= r.coord[glc_pkg::GRID_Y];
      req_bus.z_coord     <= r.coord[glc_pkg::GRID_Z];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_request(r);
      sent++;
   endtask

   task automatic load_entry(logic [SEL_W-1:0] sel, logic [IDX_W-1:0] idx,
                             logic signed [VAL_W-1:0] val);
      grid_req_type r;
      r.cmd = glc_pkg::CMD_LOAD;
      r.grid_sel = sel;
      r.entry_index = idx;
      r.entry_value = val;
      foreach (r.coord[i]) r.coord[i] = $urandom;
      send_request(r);
   endtask

   task automatic locate(logic signed [VAL_W-1:0] t, logic signed [VAL_W-1:0] x,
                         logic signed [VAL_W-1:0] y, logic signed [VAL_W-1:0] z);
      grid_req_type r;
      r.cmd = glc_pkg::CMD_LOCATE;
      r.grid_sel = SEL_W'($urandom);
      r.entry_index = IDX_W'($urandom);
      r.entry_value = $urandom;
      r.coord = '{t, x, y, z};
      send_request(r);
   endtask

   // wait for all responses, then let any trailing work settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (board.expected_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_lengths(logic [LEN_W-1:0] t, logic [LEN_W-1:0] x,
                                logic [LEN_W-1:0] y, logic [LEN_W-1:0] z);
      logic [CSR_IDX_W-1:0] regs [NUM_GRIDS];
      logic [LEN_W-1:0]     vals [NUM_GRIDS];
      regs = '{glc_pkg::CSR_TIME_LEN, glc_pkg::CSR_X_EDGES, glc_pkg::CSR_Y_EDGES,
               glc_pkg::CSR_Z_EDGES};
      vals = '{t, x, y, z};
      for (int i = 0; i < NUM_GRIDS; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= regs[i];
         csr_bus.data  <= vals[i];
         @(posedge clock);
         while (!csr_bus.ready) @(posedge clock);
         board.set_len(regs[i], vals[i]);
      end
      csr_bus.valid <= 1'b0;
   endtask

   // fill entries 0..n-1: sorted wide, sorted narrow with repeats, or unsorted
   task automatic load_grid(int g);
      int unsigned n, style;
      int          vals [$];
      int          acc;
      n = board.span(g);
      style = $urandom_range(0, 19);
      acc = int'($urandom_range(0, 4000)) - 2000;
      acc = acc * 16384;
      for (int i = 0; i < n; i++) begin
         if (style >= 10 && style < 17) begin
            acc += int'($urandom_range(0, 3)) * 16384;
            vals.insert(vals.size(), acc);
         end else begin
            vals.insert(vals.size(), $urandom);
         end
      end
      if (style < 10) vals.sort();
      for (int i = 0; i < n; i++) load_entry(SEL_W'(g), IDX_W'(i), vals[i]);
   endtask

   function automatic logic signed [VAL_W-1:0] pick_coord(int g);
      int unsigned             n, i;
      logic signed [VAL_W-1:0] e, e2;
      n = board.span(g);
      i = $urandom_range(0, n - 1);
      e = board.grid[g][i];
      e2 = board.grid[g][(i + 1 < n) ? i + 1 : i];
      case ($urandom_range(0, 7))
         0, 1: return $urandom;
         2: return e;
         3: return e - 1;
         4: return e + 1;
         5: return VAL_W'((longint'(e) + longint'(e2)) >>> 1);
         6: return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
         default: return e + int'($urandom_range(0, 131072)) - Q_ONE;
      endcase
   endfunction

   task automatic random_item();
      if ($urandom_range(0, 4) == 0) begin
         load_entry(SEL_W'($urandom), IDX_W'($urandom), $urandom);
      end else begin
         locate(pick_coord(glc_pkg::GRID_TIME), pick_coord(glc_pkg::GRID_X),
                pick_coord(glc_pkg::GRID_Y), pick_coord(glc_pkg::GRID_Z));
      end
   endtask

   task automatic run_phase(logic [LEN_W-1:0] t, logic [LEN_W-1:0] x,
                            logic [LEN_W-1:0] y, logic [LEN_W-1:0] z,
                            int items, bit flood);
      drain();
      write_lengths(t, x, y, z);
      for (int g = 0; g < NUM_GRIDS; g++) load_grid(g);
      if (flood) hold_asks++;
      repeat (items) random_item();
   endtask

   initial begin : rsp_side
      int           stall, hold_seen;
      cell_set_type got;
      stall = 0;
      hold_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
            got[glc_pkg::GRID_TIME] = rsp_bus.time_index;
            got[glc_pkg::GRID_X]    = rsp_bus.x_cell;
            got[glc_pkg::GRID_Y]    = rsp_bus.y_cell;
            got[glc_pkg::GRID_Z]    = rsp_bus.z_cell;
            board.check_cells(got);
         end
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            stall = HOLD_CYCLES;
         end else if (stall == 0 && !quiet && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 8);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.cmd         <= glc_pkg::CMD_LOAD;
      req_bus.grid_sel    <= glc_pkg::GRID_TIME;
      req_bus.entry_index <= '0;
      req_bus.entry_value <= '0;
      req_bus.time_coord  <= '0;
      req_bus.x_coord     <= '0;
      req_bus.y_coord     <= '0;
      req_bus.z_coord     <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= glc_pkg::CSR_TIME_LEN;
      csr_bus.data        <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // lengths straight out of reset: one time center, two cell boundaries per axis
      load_entry(glc_pkg::GRID_TIME, IDX_W'(0), '0);
      load_entry(glc_pkg::GRID_X, IDX_W'(0), VAL_MIN);
      load_entry(glc_pkg::GRID_X, IDX_W'(1), VAL_MAX);
      load_entry(glc_pkg::GRID_Y, IDX_W'(0), -Q_ONE);
      load_entry(glc_pkg::GRID_Y, IDX_W'(1), Q_ONE);
      load_entry(glc_pkg::GRID_Z, IDX_W'(0), Q_ONE);
      load_entry(glc_pkg::GRID_Z, IDX_W'(1), Q_ONE);
      load_entry(glc_pkg::GRID_Z, IDX_W'(GRID_DEPTH_DEF - 1), VAL_MIN);
      locate(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
      locate(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
      locate('0, '0, '0, '0);
      locate(-Q_ONE, -Q_ONE, Q_ONE, Q_ONE);

      // lengths below the minimum saturate; three centers for tie checks
      drain();
      write_lengths(LEN_W'(3), LEN_W'(0), LEN_W'(1), LEN_W'(3));
      load_entry(glc_pkg::GRID_TIME, IDX_W'(0), -Q_ONE);
      load_entry(glc_pkg::GRID_TIME, IDX_W'(1), '0);
      load_entry(glc_pkg::GRID_TIME, IDX_W'(2), Q_ONE);
      load_entry(glc_pkg::GRID_Z, IDX_W'(2), 3 * Q_ONE);
      locate(-(Q_ONE / 2), VAL_MAX, VAL_MIN, Q_ONE);
      locate(Q_ONE / 2, '0, VAL_MAX, Q_ONE + 1);
      locate(VAL_MAX, VAL_MAX, VAL_MIN, VAL_MAX);
      locate(1, VAL_MIN, '0, 2 * Q_ONE);
      locate(-Q_ONE - 1, -1, 1, VAL_MIN);

      // full depth on the time grid, its length above the maximum saturates
      quiet = 1'b0;
      run_phase(LEN_W'(2047), LEN_W'(2), LEN_W'(3), LEN_W'(5), 40, 1'b0);

      // long receiver hold while requests keep coming
      run_phase(LEN_W'(9), LEN_W'(12), LEN_W'(16), LEN_W'(7), 150, 1'b1);

      while (sent < ITEM_TARGET - TAIL_ITEMS) begin
         quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0) begin
            run_phase(LEN_W'($urandom_range(30, 80)), LEN_W'($urandom_range(30, 80)),
                      LEN_W'($urandom_range(30, 80)), LEN_W'($urandom_range(30, 80)),
                      $urandom_range(20, 60), 1'b0);
         end else begin
            run_phase(LEN_W'($urandom_range(0, 20)), LEN_W'($urandom_range(0, 20)),
                      LEN_W'($urandom_range(0, 20)), LEN_W'($urandom_range(0, 20)),
                      $urandom_range(20, 80), 1'b0);
         end
      end

      quiet = 1'b1;
      run_phase(LEN_W'($urandom_range(1, 16)), LEN_W'($urandom_range(2, 16)),
                LEN_W'($urandom_range(2, 16)), LEN_W'($urandom_range(2, 16)), 100, 1'b0);
      drain();

      if (board.errors == 0 && board.expected_cells.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
